### rtl/heading_p_controller_defines.svh
// Assertion macros shared by the heading controller RTL.
`ifndef HEADING_P_CONTROLLER_DEFINES_SVH
`define HEADING_P_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the heading controller.
package hpc_pkg;

  // Datapath widths
  localparam int DATA_W = 36;            // Q.30 angles and scaled CORDIC vector
  localparam int DIFF_W = 17;            // position difference
  localparam int ERR13_W = DATA_W - 17;  // error rounded to Q3.13
  localparam int ITER_W = 5;             // index into the 24-entry table
  localparam int ITER_MAX = 24;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 32;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  // Fixed-point angle constants, Q.30
  localparam logic signed [DATA_W-1:0] PI_Q30 = DATA_W'(64'sd3373259426);
  localparam logic signed [DATA_W-1:0] HALF_PI_Q30 = DATA_W'(64'sd1686629713);
  localparam logic signed [DATA_W-1:0] ONE_Q30 = DATA_W'(64'sd1073741824);
  localparam logic signed [DATA_W-1:0] INV_GAIN_Q30 = DATA_W'(64'sd652032874);

  // Register reset values
  localparam logic [14:0] V_MAX_RST = 15'd16384;
  localparam logic [14:0] ANG_LIM_RST = 15'd12288;
  localparam logic [15:0] K_ANG_RST = 16'd8192;
  localparam logic [15:0] STOP_DIST_RST = 16'd307;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_V_MAX = 2'd0,
    REG_ANG_LIM = 2'd1,
    REG_K_ANG = 2'd2,
    REG_STOP_DIST = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] heading_angle;
    logic [15:0]        distance_to_goal;
    logic [31:0]        sim_step;
    logic               goal_reached;
    logic               collided;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [31:0]        command_seq;
  } out_item_t;

  // CORDIC vector
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } cordic_vec_t;

  // CORDIC control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
    logic rot;   // 1: rotation (cos), 0: vectoring (atan2)
  } cordic_ctl_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [DATA_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = 31'd0;
    endcase
    return $signed({{(DATA_W-31){1'b0}}, v});
  endfunction

endpackage

### rtl/hpc_cordic.sv
`timescale 1ns / 1ps
// Shared CORDIC micro-rotation unit: one iteration per cycle while step is high, vectoring or rotation.
module hpc_cordic #(
  parameter int CORDIC_ITERATIONS = hpc_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hpc_pkg::cordic_ctl_t ctl,
  input  hpc_pkg::cordic_vec_t init,
  output hpc_pkg::cordic_vec_t res,
  output logic                last
);
  import hpc_pkg::*;

  localparam logic [ITER_W-1:0] LastIter = ITER_W'(CORDIC_ITERATIONS - 1);

  logic signed [DATA_W-1:0] x, y, z;
  logic signed [DATA_W-1:0] xs, ys, ang;
  logic [ITER_W-1:0]        iter;
  logic                     sub;

  // shifted terms and direction of this micro-rotation
  always_comb begin
    xs  = x >>> iter;
    ys  = y >>> iter;
    ang = atan_entry(iter);
    sub = ctl.rot ? ~z[DATA_W-1] : y[DATA_W-1];
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (ctl.load) begin
      iter <= '0;
    end else if (ctl.step) begin
      iter <= iter + 1'b1;
    end
  end

  // vector registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= init.x;
      y <= init.y;
      z <= init.z;
    end else if (ctl.step) begin
      if (sub) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
    end
  end

  assign res  = '{x: x, y: y, z: z};
  assign last = (iter == LastIter);

endmodule

### rtl/hpc_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module hpc_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [hpc_pkg::MUL_A_W-1:0]  a,
  input  logic signed [hpc_pkg::MUL_B_W-1:0]  b,
  output logic signed [hpc_pkg::PROD_W-1:0]   prod
);
  import hpc_pkg::*;

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

### rtl/heading_p_controller.sv
`timescale 1ns / 1ps
// Top level of the proportional heading go-to-goal controller.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall   | one robot state sample
//   out     | output    | out_valid/out_stall | one velocity command
//   cfg     | input     | cfg_wen             | one register write
//
// For a new sample outside the goal tolerance, the shared CORDIC unit runs once
// vectoring for the bearing (skipped for a zero offset) and once rotating for the
// cosine, one micro-rotation per cycle, then the shared multiplier serves the
// angular and linear terms in turn.
// Ignored samples stay in idle; samples inside the goal tolerance go straight to finish.
// in_stall is high while a sample is in work; the output register lets the next
// sample enter while a command waits, and a command blocks only on out_stall.
// Reset is synchronous and restores register defaults, the step and command
// counters and the halted latch.
`include "heading_p_controller_defines.svh"

module heading_p_controller #(
  parameter int CORDIC_ITERATIONS = hpc_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hpc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hpc_pkg::out_item_t out_data,
  input  logic              cfg_wen,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import hpc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_VEC    = 10'b0000000010,
    S_ERR    = 10'b0000000100,
    S_WRAP   = 10'b0000001000,
    S_ROTL   = 10'b0000010000,
    S_ROT    = 10'b0000100000,
    S_MANG   = 10'b0001000000,
    S_ANG    = 10'b0010000000,
    S_LIN    = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [14:0] v_max, ang_lim;
  logic [15:0] k_ang, stop_dist;

  // control state
  logic [31:0] last_step_seen, command_count;
  logic        halted;

  // working registers
  logic signed [15:0]        heading;
  logic                      zero_off;
  logic                      cos_zero;
  logic signed [DATA_W-1:0]  err;
  logic signed [ERR13_W-1:0] err13;
  logic [14:0]               linear;
  logic signed [15:0]        angular;

  // shared units
  cordic_ctl_t              cctl;
  cordic_vec_t              cinit, cres;
  logic                     clast;
  logic                     mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // combinational helpers
  logic                      accept, new_cmd, far;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [DATA_W-1:0]  sx, sy;
  cordic_vec_t               pre;
  logic signed [DATA_W-1:0]  err_raw, err_wrap, err_rnd, xc;
  logic signed [PROD_W-1:0]  lim, ang_rnd;
  logic [PROD_W-1:0]         lin_rnd;
  logic                      out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign new_cmd  = !halted && !in_data.goal_reached && !in_data.collided &&
                    (in_data.sim_step != last_step_seen);
  assign far      = (in_data.distance_to_goal >= stop_dist);
  assign out_free = !out_valid || !out_stall;

  // offset to goal, scaled by 2^14, with quadrant pre-rotation
  always_comb begin
    dx = DIFF_W'(in_data.target_x) - DIFF_W'(in_data.pos_x);
    dy = DIFF_W'(in_data.target_y) - DIFF_W'(in_data.pos_y);
    sx = DATA_W'(dx) <<< 14;
    sy = DATA_W'(dy) <<< 14;
    pre = '{x: sx, y: sy, z: '0};
    if (dx < 0) begin
      if (dy >= 0) begin
        pre = '{x: sy, y: -sx, z: HALF_PI_Q30};
      end else begin
        pre = '{x: -sy, y: sx, z: -HALF_PI_Q30};
      end
    end
  end

  // bearing error, wrap and rounding
  always_comb begin
    err_raw = (zero_off ? '0 : cres.z) - (DATA_W'(heading) <<< 17);
    err_wrap = err;
    if (err > PI_Q30) begin
      err_wrap = err - (PI_Q30 <<< 1);
    end else if (err < -PI_Q30) begin
      err_wrap = err + (PI_Q30 <<< 1);
    end
    err_rnd = err + DATA_W'(65536);
  end

  // angular clamp/round and linear operand
  always_comb begin
    lim     = PROD_W'(ang_lim) <<< 12;
    ang_rnd = (prod + PROD_W'(2048)) >>> 12;
    lin_rnd = prod + (PROD_W'(1) <<< 29);
    xc = cres.x;
    if (cres.x < 0) begin
      xc = '0;
    end else if (cres.x > ONE_Q30) begin
      xc = ONE_Q30;
    end
    if (cos_zero) begin
      xc = '0;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    cctl   = '{load: 1'b0, step: 1'b0, rot: 1'b0};
    cinit  = pre;
    mul_en = 1'b0;
    mul_a  = $signed({1'b0, k_ang});
    mul_b  = MUL_B_W'(err13);
    case (state)
      S_IDLE: begin
        if (accept && new_cmd) begin
          if (far) begin
            cctl.load  = 1'b1;
            state_next = S_VEC;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_VEC: begin
        cctl.step = !zero_off;
        if (clast || zero_off) begin
          state_next = S_ERR;
        end
      end
      S_ERR: state_next = S_WRAP;
      S_WRAP: state_next = S_ROTL;
      S_ROTL: begin
        cctl.load  = 1'b1;
        cctl.rot   = 1'b1;
        cinit      = '{x: INV_GAIN_Q30, y: '0, z: err};
        state_next = S_ROT;
      end
      S_ROT: begin
        cctl.step = 1'b1;
        cctl.rot  = 1'b1;
        if (clast) begin
          state_next = S_MANG;
        end
      end
      S_MANG: begin
        mul_en     = 1'b1;
        state_next = S_ANG;
      end
      S_ANG: begin
        mul_en     = 1'b1;
        mul_a      = $signed({2'b00, v_max});
        mul_b      = xc[MUL_B_W-1:0];
        state_next = S_LIN;
      end
      S_LIN: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  hpc_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cctl),
    .init (cinit),
    .res  (cres),
    .last (clast)
  );

  hpc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v_max     <= V_MAX_RST;
      ang_lim   <= ANG_LIM_RST;
      k_ang     <= K_ANG_RST;
      stop_dist <= STOP_DIST_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_V_MAX:     v_max     <= cfg_data[14:0];
        REG_ANG_LIM:   ang_lim   <= cfg_data[14:0];
        REG_K_ANG:     k_ang     <= cfg_data;
        REG_STOP_DIST: stop_dist <= cfg_data;
        default: ;
      endcase
    end
  end

  // state, step tracking, halt latch, output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_step_seen <= '1;
      command_count  <= '0;
      halted         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && !halted && (in_data.goal_reached || in_data.collided)) begin
        halted <= 1'b1;
      end
      if (accept && new_cmd) begin
        last_step_seen <= in_data.sim_step;
      end
      if (state == S_FINISH && out_free) begin
        out_valid     <= 1'b1;
        command_count <= command_count + 32'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        heading  <= in_data.heading_angle;
        zero_off <= (dx == '0) && (dy == '0);
        linear   <= '0;
        angular  <= '0;
      end
      S_ERR:  err <= err_raw;
      S_WRAP: err <= err_wrap;
      S_ROTL: begin
        err13    <= err_rnd[DATA_W-1:17];
        cos_zero <= (err >= HALF_PI_Q30) || (err <= -HALF_PI_Q30);
      end
      S_ANG: begin
        if (prod > lim) begin
          angular <= $signed({1'b0, ang_lim});
        end else if (prod < -lim) begin
          angular <= -$signed({1'b0, ang_lim});
        end else begin
          angular <= ang_rnd[15:0];
        end
      end
      S_LIN: linear <= lin_rnd[44:30];
      default: ;
    endcase
    if (state == S_FINISH && out_free) begin
      out_data <= '{linear_cmd: linear, angular_cmd: angular, command_seq: command_count};
    end
  end

  // checks
  `HPC_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted, "halted latch cleared")
  `HPC_ASSERT_NOW(a_halt_idle, clk, rst, halted, state == S_IDLE, "work started while halted")
  `HPC_ASSERT_NOW(a_seq_count, clk, rst, out_valid, out_data.command_seq + 32'd1 == command_count, "sequence number out of step with count")
  `HPC_ASSERT_NOW(a_lin_bound, clk, rst, out_valid, out_data.linear_cmd <= v_max, "linear command above v_max")

endmodule

### tb/heading_cmd_checker.sv
`timescale 1ns / 1ps
// Command checker for the heading controller: predicts each velocity command and compares it.
module heading_cmd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  hpc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  hpc_pkg::out_item_t out_data,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fails,
  output int                 pending
);

  localparam int     TURNS = hpc_pkg::CORDIC_ITERATIONS_DEF;
  localparam longint PI_RAD = 64'sd3373259426;
  localparam longint HALF_PI_RAD = 64'sd1686629713;
  localparam longint UNIT_Q30 = 64'sd1073741824;
  localparam longint GAIN_INV = 64'sd652032874;

  // atan(2^-i), Q.30 radians
  longint atan_q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  // Register copies and controller state
  logic [14:0] vmax_q;
  logic [14:0] omega_q;
  logic [15:0] kang_q;
  logic [15:0] tol_q;
  logic [31:0] last_step_q;
  logic [31:0] cmd_count_q;
  logic        halted_q;

  hpc_pkg::out_item_t upcoming_cmds [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Vectoring CORDIC: bearing of (dx, dy) in Q.30
  function automatic longint bearing_q30(input longint dx, input longint dy);
    longint x, y, z, t, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 16384;
    y = dy * 16384;
    z = 0;
    // left half plane: pre-rotate by a quarter turn
    if (dx < 0) begin
      if (dy >= 0) begin
        t = y; y = -x; x = t; z = HALF_PI_RAD;
      end else begin
        t = -y; y = x; x = t; z = -HALF_PI_RAD;
      end
    end
    for (int i = 0; i < TURNS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_q30[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_q30[i];
      end
    end
    return z;
  endfunction

  // Rotation CORDIC: cosine in Q.30, zero at or beyond +-pi/2
  function automatic longint cosine_q30(input longint ang);
    longint x, y, z, xs, ys;
    if (ang >= HALF_PI_RAD || ang <= -HALF_PI_RAD) return 0;
    x = GAIN_INV;
    y = 0;
    z = ang;
    for (int i = 0; i < TURNS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_q30[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_q30[i];
      end
    end
    if (x < 0) x = 0;
    if (x > UNIT_Q30) x = UNIT_Q30;
    return x;
  endfunction

  // Advance the controller state by one sample; returns 1 when a command follows
  function automatic bit predict_command(input hpc_pkg::in_item_t s,
                                         output hpc_pkg::out_item_t cmd);
    longint dx, dy, err, err13, prod, lim, ang, lin;
    cmd = '0;
    if (halted_q) return 0;
    if (s.goal_reached || s.collided) begin
      halted_q = 1'b1;
      return 0;
    end
    if (s.sim_step == last_step_q) return 0;
    last_step_q = s.sim_step;
    ang = 0;
    lin = 0;
    if (s.distance_to_goal >= tol_q) begin
      dx = longint'(s.target_x) - longint'(s.pos_x);
      dy = longint'(s.target_y) - longint'(s.pos_y);
      err = bearing_q30(dx, dy) - longint'(s.heading_angle) * 131072;
      if (err > PI_RAD) err = err - 2 * PI_RAD;
      else if (err < -PI_RAD) err = err + 2 * PI_RAD;
      // angular: error to Q3.13, gain, clamp or round
      err13 = (err + 65536) >>> 17;
      prod = longint'(kang_q) * err13;
      lim = longint'(omega_q) * 4096;
      if (prod > lim) ang = longint'(omega_q);
      else if (prod < -lim) ang = -longint'(omega_q);
      else ang = (prod + 2048) >>> 12;
      lin = (longint'(vmax_q) * cosine_q30(err) + 64'sd536870912) >>> 30;
    end
    cmd.linear_cmd = lin[14:0];
    cmd.angular_cmd = ang[15:0];
    cmd.command_seq = cmd_count_q;
    cmd_count_q = cmd_count_q + 32'd1;
    return 1;
  endfunction

  always @(posedge clk) begin
    hpc_pkg::out_item_t want, cmd;
    if (rst) begin
      vmax_q = hpc_pkg::V_MAX_RST;
      omega_q = hpc_pkg::ANG_LIM_RST;
      kang_q = hpc_pkg::K_ANG_RST;
      tol_q = hpc_pkg::STOP_DIST_RST;
      last_step_q = '1;
      cmd_count_q = '0;
      halted_q = 1'b0;
      upcoming_cmds.delete();
    end else begin
      // output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (upcoming_cmds.size() == 0) begin
          report_mismatch("unexpected command, seq", out_data.command_seq, -1);
        end else begin
          want = upcoming_cmds.pop_front();
          if (out_data.linear_cmd !== want.linear_cmd)
            report_mismatch("linear_cmd", out_data.linear_cmd, want.linear_cmd);
          if (out_data.angular_cmd !== want.angular_cmd)
            report_mismatch("angular_cmd", longint'(out_data.angular_cmd),
                            longint'(want.angular_cmd));
          if (out_data.command_seq !== want.command_seq)
            report_mismatch("command_seq", out_data.command_seq, want.command_seq);
        end
      end
      // register writes keep only the register width
      if (cfg_wen) begin
        case (hpc_pkg::cfg_reg_t'(cfg_index))
          hpc_pkg::REG_V_MAX:     vmax_q = cfg_data[14:0];
          hpc_pkg::REG_ANG_LIM:   omega_q = cfg_data[14:0];
          hpc_pkg::REG_K_ANG:     kang_q = cfg_data;
          hpc_pkg::REG_STOP_DIST: tol_q = cfg_data;
          default: ;
        endcase
      end
      // input beat
      if (in_valid && !in_stall) begin
        if (predict_command(in_data, cmd)) upcoming_cmds.push_back(cmd);
      end
    end
    pending = upcoming_cmds.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the heading controller: stimulus, receiver stalls and verdict.
module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 200;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  hpc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  hpc_pkg::out_item_t out_data;
  logic               cfg_wen;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fails;
  int                 pending;

  int          cycles = 0;
  int          burst_left = 0;
  bit          hold_off_req = 1'b0;
  logic [31:0] step_now;
  logic [15:0] tol_now;

  heading_p_controller dut (.*);
  heading_cmd_checker checker_i (.*);

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall stretches of varying density, plus one long hold-off on request
  initial begin : receiver
    int mode, run;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run = $urandom_range(16, 128);
      repeat (run) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
        end
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = $urandom_range(0, 1);
          2: out_stall = ($urandom_range(0, 7) == 0);
          default: out_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one beat, wait for acceptance, then maybe open a gap between bursts
  task automatic offer_sample(input hpc_pkg::in_item_t s);
    in_data = s;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic offer_state(input logic [15:0] px, py, tx, ty, hd, gdist,
                             input logic [31:0] step);
    hpc_pkg::in_item_t s;
    s = '0;
    s.pos_x = px;
    s.pos_y = py;
    s.target_x = tx;
    s.target_y = ty;
    s.heading_angle = hd;
    s.distance_to_goal = gdist;
    s.sim_step = step;
    offer_sample(s);
  endtask

  // Wait until every command has arrived and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [15:0] v, w, k, t);
    cfg_wen = 1'b1;
    cfg_index = hpc_pkg::REG_V_MAX;
    cfg_data = v;
    @(negedge clk);
    cfg_index = hpc_pkg::REG_ANG_LIM;
    cfg_data = w;
    @(negedge clk);
    cfg_index = hpc_pkg::REG_K_ANG;
    cfg_data = k;
    @(negedge clk);
    cfg_index = hpc_pkg::REG_STOP_DIST;
    cfg_data = t;
    @(negedge clk);
    cfg_wen = 1'b0;
    tol_now = t;
  endtask

  // Random robot sample with clear flags; geometry and distance biased to corners
  function automatic hpc_pkg::in_item_t next_sample();
    hpc_pkg::in_item_t s;
    int pick, d;
    s = '0;
    s.pos_x = 16'($urandom);
    s.pos_y = 16'($urandom);
    s.target_x = 16'($urandom);
    s.target_y = 16'($urandom);
    pick = $urandom_range(0, 9);
    case (pick)
      4, 5: begin
        s.target_x = s.pos_x + 16'($urandom_range(0, 400)) - 16'd200;
        s.target_y = s.pos_y + 16'($urandom_range(0, 400)) - 16'd200;
      end
      6: begin
        s.target_x = s.pos_x;
        s.target_y = s.pos_y;
      end
      7: s.target_x = s.pos_x;
      8: s.target_y = s.pos_y;
      9: begin
        s.pos_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        s.pos_y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        s.target_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        s.target_y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      end
      default: ;
    endcase
    s.heading_angle = 16'($urandom);
    if ($urandom_range(0, 7) == 0)
      s.heading_angle = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    // distance: anywhere, or within two of the stop threshold
    s.distance_to_goal = 16'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      d = int'(tol_now) + int'($urandom_range(0, 4)) - 2;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      s.distance_to_goal = 16'(d);
    end
    // step: mostly the next one, sometimes a repeat or a jump
    pick = $urandom_range(0, 19);
    if (pick == 2) step_now = $urandom;
    else if (pick == 3) step_now = '1;
    else if (pick > 3) step_now = step_now + 32'd1;
    s.sim_step = step_now;
    return s;
  endfunction

  initial begin : stimulus
    hpc_pkg::in_item_t s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wen = 1'b0;
    cfg_index = hpc_pkg::REG_V_MAX;
    cfg_data = '0;
    tol_now = hpc_pkg::STOP_DIST_RST;
    step_now = 32'd100;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed samples at the reset register values
    offer_state(16'd100, 16'd100, 16'd2000, 16'd3000, 16'd0, 16'd5000, 32'hFFFF_FFFF);
    offer_state(16'd500, 16'd500, 16'd500, 16'd500, 16'd0, 16'd5000, 32'd0);
    offer_state(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 32'd1);
    offer_state(16'h7FFF, 16'd0, 16'h8000, 16'd0, 16'h8000, 16'hFFFF, 32'd2);
    offer_state(16'd1000, 16'd1000, -16'd1000, -16'd3000, 16'd0, 16'd4000, 32'd3);
    offer_state(16'd0, 16'd0, 16'd0, 16'd5000, 16'd0, 16'd4000, 32'd4);
    offer_state(16'd0, 16'd0, 16'd0, -16'd5000, 16'd0, 16'd4000, 32'd5);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd0, 16'd0, 16'd4000, 32'd6);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd0, 16'd100, 16'd4000, 32'd6);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd900, 16'd0, 16'd306, 32'd7);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd900, 16'd0, 16'd307, 32'd8);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd900, 16'd0, 16'd0, 32'd9);
    // cosine cut-off at a quarter turn either side
    offer_state(16'd0, 16'd0, 16'd5000, 16'd0, 16'd12868, 16'd4000, 32'd10);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd0, 16'd12867, 16'd4000, 32'd11);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd0, -16'd12868, 16'd4000, 32'd12);
    // error wraps in both directions
    offer_state(16'd0, 16'd0, 16'd0, 16'd5000, 16'h8000, 16'd4000, 32'd13);
    offer_state(16'd0, 16'd0, 16'd0, -16'd5000, 16'h7FFF, 16'd4000, 32'd14);
    offer_state(16'd0, 16'd0, -16'd5000, 16'd1, 16'd0, 16'd4000, 32'd15);
    offer_state(16'd0, 16'd0, 16'd5000, 16'd100, 16'd0, 16'd4000, 32'd1);
    offer_state(16'd10, 16'd20, 16'd3000, -16'd700, 16'd50, 16'd4000, 32'h7FFF_FFFF);
    offer_state(16'd10, 16'd20, 16'd3000, -16'd700, 16'd50, 16'd4000, 32'hFFFF_FFFF);
    offer_state(16'd10, 16'd20, -16'd3000, 16'd700, 16'd50, 16'd4000, 32'd0);
    settle();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_config(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd0);
        1: load_config(16'h8000, 16'd0, 16'd0, 16'hFFFF);
        2: load_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                       16'($urandom), 16'($urandom_range(0, 2048)));
        3: load_config(16'hFFFF, 16'($urandom_range(1000, 20000)),
                       16'($urandom), 16'($urandom_range(0, 600)));
        default: load_config(hpc_pkg::V_MAX_RST, hpc_pkg::ANG_LIM_RST,
                             16'($urandom_range(1000, 20000)), hpc_pkg::STOP_DIST_RST);
      endcase
      // receiver holds off while beats keep coming, so the input backs up
      if (phase == 2) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) offer_sample(next_sample());
      settle();
    end

    // Halt latch: a flagged sample, then everything after it is ignored
    repeat (2) offer_sample(next_sample());
    s = next_sample();
    s.goal_reached = 1'b1;
    offer_sample(s);
    s = next_sample();
    s.collided = 1'b1;
    offer_sample(s);
    s = next_sample();
    s.goal_reached = 1'b1;
    s.collided = 1'b1;
    offer_sample(s);
    repeat (3) offer_sample(next_sample());
    settle();

    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
